### rtl/eba_pkg.sv
// Package with the shared types, opcodes and constants of the accumulator CPU.
package eba_pkg;

  typedef enum logic [1:0] {
    MODE_WRITE = 2'd0,
    MODE_READ  = 2'd1,
    MODE_RESET = 2'd2,
    MODE_EXEC  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STOP_NONE    = 2'd0,
    STOP_BRK     = 2'd1,
    STOP_UNKNOWN = 2'd2
  } stop_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD,
    ST_VEC_LO,
    ST_VEC_HI,
    ST_OPC,
    ST_OPR1,
    ST_OPR2,
    ST_DATA,
    ST_WR,
    ST_PUSH2,
    ST_PULL2,
    ST_DONE,
    ST_OUT
  } state_t;

  localparam logic [15:0] VEC_LO     = 16'hFFFC;
  localparam logic [15:0] VEC_HI     = 16'hFFFD;
  localparam logic [15:0] STACK_PAGE = 16'h0100;
  localparam logic [7:0]  SP_INIT    = 8'hFF;
  localparam logic [7:0]  SIGN_BIT   = 8'h80;
  localparam logic [15:0] NEG_EXT    = 16'hFF00;

  localparam int FL_C = 0;
  localparam int FL_Z = 1;
  localparam int FL_V = 2;
  localparam int FL_N = 3;

  localparam logic [7:0] OP_ADC_I = 8'h69, OP_ADC_A = 8'h6D;
  localparam logic [7:0] OP_AND_I = 8'h29, OP_AND_A = 8'h2D;
  localparam logic [7:0] OP_EOR_I = 8'h49, OP_EOR_A = 8'h4D, OP_EOR_Z = 8'h45;
  localparam logic [7:0] OP_ASL = 8'h0A, OP_LSR = 8'h4A;
  localparam logic [7:0] OP_BEQ = 8'hF0, OP_BNE = 8'hD0, OP_BMI = 8'h30;
  localparam logic [7:0] OP_BPL = 8'h10, OP_BCC = 8'h90, OP_BVS = 8'h70;
  localparam logic [7:0] OP_CMP_I = 8'hC9, OP_CMP_A = 8'hCD, OP_CPX_I = 8'hE0;
  localparam logic [7:0] OP_CPY_I = 8'hC0, OP_CPY_A = 8'hCC, OP_CPY_Z = 8'hC4;
  localparam logic [7:0] OP_INX = 8'hE8, OP_INY = 8'hC8, OP_DEY = 8'h88;
  localparam logic [7:0] OP_DEA = 8'h3A;
  localparam logic [7:0] OP_JMP = 8'h4C, OP_JSR = 8'h20, OP_RTS = 8'h60;
  localparam logic [7:0] OP_LDA_I = 8'hA9, OP_LDA_Z = 8'hA5, OP_LDA_A = 8'hAD;
  localparam logic [7:0] OP_LDA_AY = 8'hB9;
  localparam logic [7:0] OP_LDX_I = 8'hA2, OP_LDX_Z = 8'hA6;
  localparam logic [7:0] OP_LDY_I = 8'hA0, OP_LDY_A = 8'hAC;
  localparam logic [7:0] OP_NOP = 8'hEA, OP_PHA = 8'h48, OP_PLA = 8'h68;
  localparam logic [7:0] OP_SBC_I = 8'hE9, OP_SBC_A = 8'hED;
  localparam logic [7:0] OP_STA_A = 8'h8D, OP_STA_AX = 8'h9D, OP_STA_AY = 8'h99;
  localparam logic [7:0] OP_STA_Z = 8'h85, OP_STX_Z = 8'h86, OP_STY_Z = 8'h84;
  localparam logic [7:0] OP_TAX = 8'hAA, OP_TXA = 8'h8A, OP_BRK = 8'h00;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] address;
    logic [7:0]  data;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic [15:0] program_counter;
    logic [7:0]  accumulator;
    logic [7:0]  index_x;
    logic [7:0]  index_y;
    logic [7:0]  stack_pointer;
    logic [3:0]  flags;
    logic [1:0]  stopped;
  } out_item_t;

  // Operand read after the opcode: immediate, zero page or relative (1), absolute (2).
  function automatic logic [1:0] opr_bytes(input logic [7:0] op);
    case (op) inside
      OP_ADC_A, OP_AND_A, OP_EOR_A, OP_CMP_A, OP_CPY_A, OP_JMP, OP_JSR,
      OP_LDA_A, OP_LDA_AY, OP_LDY_A, OP_SBC_A, OP_STA_A, OP_STA_AX,
      OP_STA_AY: opr_bytes = 2'd2;
      OP_ADC_I, OP_AND_I, OP_EOR_I, OP_EOR_Z, OP_BEQ, OP_BNE, OP_BMI, OP_BPL,
      OP_BCC, OP_BVS, OP_CMP_I, OP_CPX_I, OP_CPY_I, OP_CPY_Z, OP_LDA_I,
      OP_LDA_Z, OP_LDX_I, OP_LDX_Z, OP_LDY_I, OP_SBC_I, OP_STA_Z, OP_STX_Z,
      OP_STY_Z: opr_bytes = 2'd1;
      default: opr_bytes = 2'd0;
    endcase
  endfunction

  // Opcodes that read a data byte from the address they fetched.
  function automatic logic needs_data(input logic [7:0] op);
    case (op) inside
      OP_ADC_A, OP_AND_A, OP_EOR_A, OP_EOR_Z, OP_CMP_A, OP_CPY_A, OP_CPY_Z,
      OP_LDA_Z, OP_LDA_A, OP_LDA_AY, OP_LDX_Z, OP_LDY_A, OP_SBC_A:
        needs_data = 1'b1;
      default: needs_data = 1'b0;
    endcase
  endfunction

endpackage

### rtl/eba_if.sv
// Valid/ready channel interface carrying one item of a parameterised type.
interface eba_if #(parameter type T = logic) (input logic clk);
  logic valid;
  logic ready;
  T     payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### rtl/eight_bit_accumulator_cpu_subset_top.sv
// Top level of the 8-bit accumulator CPU with its internal byte memory.
//
// Usage: items arrive on the in channel (mode, address, data) and each
// produces exactly one beat on the out channel holding the read byte and the
// whole register file after the item. Mode 0 writes a memory byte, mode 1
// reads one, mode 2 resets the core from the vector at FFFC/FFFD and mode 3
// executes one instruction.
// All state beyond the registers lies in one single-port synchronous memory
// of 2^MEM_ADDR_BITS bytes with registered read data; every fetch, data read,
// stack push and pull is one access to it, made in sequence.
// One item is in flight at a time; in_ready is high only while idle, so the
// block takes no new item until the result beat of the last one is taken.
// The result sits in an output register; while the receiver stalls it holds
// and no new item is taken. The memory is not cleared at reset; it must be
// loaded before use. Reset (rst_n low, synchronous) clears A, X, Y and the
// flags, sets SP to FF and PC to zero, and drops any pending beat.
module eight_bit_accumulator_cpu_subset_top #(
  parameter int MEM_ADDR_BITS = 16
) (
  input logic clk,
  input logic rst_n,
  eba_if.sink   in_ch,
  eba_if.source out_ch
);
  import eba_pkg::*;

  localparam int MEM_DEPTH = 1 << MEM_ADDR_BITS;

  logic [7:0] mem [MEM_DEPTH];
  logic [7:0] rd_q;
  logic [MEM_ADDR_BITS-1:0] m_addr;
  logic [7:0] m_wdata;
  logic       m_we;
  logic       m_re;

  state_t st_r, st_nxt;
  in_item_t item_r;
  logic [7:0]  op_r, op_nxt;
  logic [15:0] opr_r, opr_nxt;
  logic [15:0] pc_r, pc_nxt;
  logic [7:0]  a_r, a_nxt, x_r, x_nxt, y_r, y_nxt, sp_r, sp_nxt;
  logic [3:0]  fl_r, fl_nxt;
  logic [1:0]  stop_r, stop_nxt;
  logic [7:0]  rdd_r, rdd_nxt;
  logic [7:0]  val_r, val_nxt;
  logic        ovalid_r;

  logic [7:0] alu_a, alu_x, alu_y;
  logic [3:0] alu_fl;
  logic       alu_take;

  always_ff @(posedge clk) begin
    if (m_we) begin
      mem[m_addr] <= m_wdata;
    end
    if (m_re) begin
      rd_q <= mem[m_addr];
    end
  end

  eba_alu u_alu (
    .op(op_r), .val(val_r), .acc(a_r), .xr(x_r), .yr(y_r), .fl(fl_r),
    .acc_o(alu_a), .x_o(alu_x), .y_o(alu_y), .fl_o(alu_fl), .take_o(alu_take)
  );

  assign in_ch.ready = (st_r == ST_IDLE);

  always_comb begin
    st_nxt   = st_r;
    op_nxt   = op_r;
    opr_nxt  = opr_r;
    pc_nxt   = pc_r;
    a_nxt    = a_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    sp_nxt   = sp_r;
    fl_nxt   = fl_r;
    stop_nxt = stop_r;
    rdd_nxt  = rdd_r;
    val_nxt  = val_r;
    m_addr   = pc_r[MEM_ADDR_BITS-1:0];
    m_wdata  = a_r;
    m_we     = 1'b0;
    m_re     = 1'b0;
    case (st_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          stop_nxt = STOP_NONE;
          rdd_nxt  = 8'd0;
          case (mode_t'(in_ch.payload.mode))
            MODE_WRITE: begin
              m_addr = in_ch.payload.address[MEM_ADDR_BITS-1:0];
              m_wdata = in_ch.payload.data; m_we = 1'b1; st_nxt = ST_OUT;
            end
            MODE_READ: begin
              m_addr = in_ch.payload.address[MEM_ADDR_BITS-1:0];
              m_re = 1'b1; st_nxt = ST_RD;
            end
            MODE_RESET: begin
              m_addr = VEC_LO[MEM_ADDR_BITS-1:0]; m_re = 1'b1; st_nxt = ST_VEC_LO;
            end
            default: begin
              m_re = 1'b1; pc_nxt = pc_r + 16'd1; st_nxt = ST_OPC;
            end
          endcase
        end
      end
      ST_RD: begin rdd_nxt = rd_q; st_nxt = ST_OUT; end
      ST_VEC_LO: begin
        opr_nxt[7:0] = rd_q;
        m_addr = VEC_HI[MEM_ADDR_BITS-1:0]; m_re = 1'b1; st_nxt = ST_VEC_HI;
      end
      ST_VEC_HI: begin
        pc_nxt = {rd_q, opr_r[7:0]};
        a_nxt = 8'd0; x_nxt = 8'd0; y_nxt = 8'd0; fl_nxt = 4'd0; sp_nxt = SP_INIT;
        st_nxt = ST_OUT;
      end
      ST_OPC: begin
        op_nxt = rd_q;
        opr_nxt = 16'd0;
        if (opr_bytes(rd_q) != 2'd0) begin
          m_re = 1'b1; pc_nxt = pc_r + 16'd1; st_nxt = ST_OPR1;
        end else if (rd_q == OP_PHA) begin
          m_addr = MEM_ADDR_BITS'(STACK_PAGE | {8'd0, sp_r});
          m_we = 1'b1; sp_nxt = sp_r - 8'd1; st_nxt = ST_OUT;
        end else if (rd_q == OP_PLA || rd_q == OP_RTS) begin
          m_addr = MEM_ADDR_BITS'(STACK_PAGE | {8'd0, sp_r + 8'd1});
          m_re = 1'b1; sp_nxt = sp_r + 8'd1;
          st_nxt = (rd_q == OP_RTS) ? ST_PULL2 : ST_DATA;
        end else if (rd_q == OP_BRK) begin
          stop_nxt = STOP_BRK; st_nxt = ST_OUT;
        end else if (rd_q == OP_ASL || rd_q == OP_LSR || rd_q == OP_INX ||
                     rd_q == OP_INY || rd_q == OP_DEY || rd_q == OP_DEA ||
                     rd_q == OP_TAX || rd_q == OP_TXA || rd_q == OP_NOP) begin
          st_nxt = ST_DONE;
        end else begin
          stop_nxt = STOP_UNKNOWN; st_nxt = ST_OUT;
        end
      end
      ST_OPR1: begin
        opr_nxt = {8'd0, rd_q};
        if (opr_bytes(op_r) == 2'd2) begin
          m_re = 1'b1; pc_nxt = pc_r + 16'd1; st_nxt = ST_OPR2;
        end else if (needs_data(op_r)) begin
          m_addr = MEM_ADDR_BITS'({8'd0, rd_q}); m_re = 1'b1; st_nxt = ST_DATA;
        end else if (op_r == OP_STA_Z || op_r == OP_STX_Z || op_r == OP_STY_Z) begin
          st_nxt = ST_WR;
        end else begin
          val_nxt = rd_q; st_nxt = ST_DONE;
        end
      end
      ST_OPR2: begin
        opr_nxt = {rd_q, opr_r[7:0]};
        if (op_r == OP_LDA_AY || op_r == OP_STA_AY) begin
          opr_nxt = {rd_q, opr_r[7:0]} + {8'd0, y_r};
        end else if (op_r == OP_STA_AX) begin
          opr_nxt = {rd_q, opr_r[7:0]} + {8'd0, x_r};
        end
        if (op_r == OP_JMP) begin
          pc_nxt = {rd_q, opr_r[7:0]}; st_nxt = ST_OUT;
        end else if (op_r == OP_JSR) begin
          m_addr = MEM_ADDR_BITS'(STACK_PAGE | {8'd0, sp_r});
          m_wdata = pc_r[15:8]; m_we = 1'b1; sp_nxt = sp_r - 8'd1;
          st_nxt = ST_PUSH2;
        end else if (needs_data(op_r)) begin
          st_nxt = ST_DATA;
          m_addr = opr_nxt[MEM_ADDR_BITS-1:0]; m_re = 1'b1;
        end else begin
          st_nxt = ST_WR;
        end
      end
      ST_PUSH2: begin
        m_addr = MEM_ADDR_BITS'(STACK_PAGE | {8'd0, sp_r});
        m_wdata = pc_r[7:0]; m_we = 1'b1; sp_nxt = sp_r - 8'd1;
        pc_nxt = opr_r; st_nxt = ST_OUT;
      end
      ST_PULL2: begin
        opr_nxt[7:0] = rd_q;
        m_addr = MEM_ADDR_BITS'(STACK_PAGE | {8'd0, sp_r + 8'd1});
        m_re = 1'b1; sp_nxt = sp_r + 8'd1; st_nxt = ST_DATA;
      end
      ST_DATA: begin
        if (op_r == OP_RTS) begin
          pc_nxt = {rd_q, opr_r[7:0]}; st_nxt = ST_OUT;
        end else begin
          val_nxt = rd_q; st_nxt = ST_DONE;
        end
      end
      ST_WR: begin
        m_addr = opr_r[MEM_ADDR_BITS-1:0]; m_we = 1'b1;
        m_wdata = (op_r == OP_STX_Z) ? x_r : (op_r == OP_STY_Z) ? y_r : a_r;
        st_nxt = ST_OUT;
      end
      ST_DONE: begin
        a_nxt = alu_a; x_nxt = alu_x; y_nxt = alu_y; fl_nxt = alu_fl;
        if (alu_take) begin
          pc_nxt = pc_r + (val_r[7] ? (NEG_EXT | {8'd0, val_r}) : {8'd0, val_r});
        end
        st_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_ch.ready) begin
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      pc_r <= 16'd0; a_r <= 8'd0; x_r <= 8'd0; y_r <= 8'd0;
      sp_r <= SP_INIT; fl_r <= 4'd0; stop_r <= STOP_NONE;
      ovalid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      pc_r <= pc_nxt; a_r <= a_nxt; x_r <= x_nxt; y_r <= y_nxt;
      sp_r <= sp_nxt; fl_r <= fl_nxt; stop_r <= stop_nxt;
      ovalid_r <= (st_nxt == ST_OUT);
    end
  end

  always_ff @(posedge clk) begin
    op_r <= op_nxt; opr_r <= opr_nxt; rdd_r <= rdd_nxt; val_r <= val_nxt;
    if (in_ch.valid && in_ch.ready) begin
      item_r <= in_ch.payload;
    end
  end

  assign out_ch.valid = ovalid_r;
  always_comb begin
    out_ch.payload.read_data       = (mode_t'(item_r.mode) == MODE_READ) ? rdd_r : 8'd0;
    out_ch.payload.program_counter = pc_r;
    out_ch.payload.accumulator     = a_r;
    out_ch.payload.index_x         = x_r;
    out_ch.payload.index_y         = y_r;
    out_ch.payload.stack_pointer   = sp_r;
    out_ch.payload.flags           = fl_r;
    out_ch.payload.stopped         = stop_r;
  end
endmodule

### rtl/eba_alu.sv
// Combinational execute stage: register and flag update for one opcode.
module eba_alu (
  input  logic [7:0]  op,
  input  logic [7:0]  val,
  input  logic [7:0]  acc,
  input  logic [7:0]  xr,
  input  logic [7:0]  yr,
  input  logic [3:0]  fl,
  output logic [7:0]  acc_o,
  output logic [7:0]  x_o,
  output logic [7:0]  y_o,
  output logic [3:0]  fl_o,
  output logic        take_o
);
  import eba_pkg::*;

  logic [8:0] sum;
  logic [8:0] need;
  logic [7:0] res;
  logic [7:0] cmp_reg;
  logic       set_nz;

  always_comb begin
    acc_o   = acc;
    x_o     = xr;
    y_o     = yr;
    fl_o    = fl;
    take_o  = 1'b0;
    res     = 8'd0;
    set_nz  = 1'b0;
    cmp_reg = acc;
    sum     = {1'b0, acc} + {1'b0, val} + {8'd0, fl[FL_C]};
    need    = {1'b0, val} + {8'd0, ~fl[FL_C]};
    case (op)
      OP_ADC_I, OP_ADC_A: begin
        res = sum[7:0];
        fl_o[FL_C] = sum[8];
        fl_o[FL_V] = (~(acc[7] ^ val[7])) & (acc[7] ^ res[7]);
        acc_o = res; set_nz = 1'b1;
      end
      OP_SBC_I, OP_SBC_A: begin
        res = acc - need[7:0];
        fl_o[FL_C] = {1'b0, acc} >= need;
        fl_o[FL_V] = (acc[7] ^ res[7]) & (acc[7] ^ val[7]);
        acc_o = res; set_nz = 1'b1;
      end
      OP_AND_I, OP_AND_A: begin res = acc & val; acc_o = res; set_nz = 1'b1; end
      OP_EOR_I, OP_EOR_A, OP_EOR_Z: begin
        res = acc ^ val; acc_o = res; set_nz = 1'b1;
      end
      OP_ASL: begin
        fl_o[FL_C] = acc[7]; res = {acc[6:0], 1'b0}; acc_o = res; set_nz = 1'b1;
      end
      OP_LSR: begin
        fl_o[FL_C] = acc[0]; res = {1'b0, acc[7:1]}; acc_o = res; set_nz = 1'b1;
      end
      OP_BEQ: take_o = fl[FL_Z];
      OP_BNE: take_o = ~fl[FL_Z];
      OP_BMI: take_o = fl[FL_N];
      OP_BPL: take_o = ~fl[FL_N];
      OP_BCC: take_o = ~fl[FL_C];
      OP_BVS: take_o = fl[FL_V];
      OP_CMP_I, OP_CMP_A, OP_CPX_I, OP_CPY_I, OP_CPY_A, OP_CPY_Z: begin
        if (op == OP_CPX_I) begin
          cmp_reg = xr;
        end else if (op == OP_CMP_I || op == OP_CMP_A) begin
          cmp_reg = acc;
        end else begin
          cmp_reg = yr;
        end
        fl_o[FL_C] = cmp_reg >= val;
        res = cmp_reg - val; set_nz = 1'b1;
      end
      OP_INX: begin res = xr + 8'd1; x_o = res; set_nz = 1'b1; end
      OP_INY: begin res = yr + 8'd1; y_o = res; set_nz = 1'b1; end
      OP_DEY: begin res = yr - 8'd1; y_o = res; set_nz = 1'b1; end
      OP_DEA: begin res = acc - 8'd1; acc_o = res; set_nz = 1'b1; end
      OP_LDA_I, OP_LDA_Z, OP_LDA_A, OP_LDA_AY, OP_PLA: begin
        res = val; acc_o = res; set_nz = 1'b1;
      end
      OP_LDX_I, OP_LDX_Z: begin res = val; x_o = res; set_nz = 1'b1; end
      OP_LDY_I, OP_LDY_A: begin res = val; y_o = res; set_nz = 1'b1; end
      OP_TAX: begin res = acc; x_o = res; set_nz = 1'b1; end
      OP_TXA: begin res = xr; acc_o = res; set_nz = 1'b1; end
      default: ;
    endcase
    if (set_nz) begin
      fl_o[FL_Z] = (res == 8'd0);
      fl_o[FL_N] = (res & SIGN_BIT) != 8'd0;
    end
  end
endmodule

### verif/eba_cpu_checker.sv
`timescale 1ns / 1ps
// Checker that predicts every result beat of the accumulator CPU and compares it field by field.
module eba_cpu_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  eba_pkg::in_item_t  in_item,
  input  logic               out_valid,
  input  logic               out_ready,
  input  eba_pkg::out_item_t out_item,
  output int                 fail_count,
  output int                 pending
);
  import eba_pkg::*;

  // Image of the block's memory; mem_known marks bytes that have been written.
  logic [7:0]  mem_img [0:65535];
  bit          mem_known [0:65535];
  logic [15:0] cpu_pc;
  logic [7:0]  cpu_a;
  logic [7:0]  cpu_x;
  logic [7:0]  cpu_y;
  logic [7:0]  cpu_sp;
  logic [3:0]  cpu_fl;
  out_item_t   expected_beats [$];

  initial begin
    fail_count = 0;
    pending    = 0;
    foreach (mem_known[i]) mem_known[i] = 1'b0;
  end

  task automatic report(input string msg);
    $display("%0t mismatch: %s", $realtime, msg);
    fail_count++;
  endtask

  function automatic void store8(input logic [15:0] a, input logic [7:0] v);
    mem_img[a]   = v;
    mem_known[a] = 1'b1;
  endfunction

  function automatic logic [7:0] fetch8();
    logic [7:0] v;
    v      = mem_img[cpu_pc];
    cpu_pc = cpu_pc + 16'd1;
    return v;
  endfunction

  function automatic logic [15:0] fetch16();
    logic [7:0] lo;
    logic [7:0] hi;
    lo = fetch8();
    hi = fetch8();
    return {hi, lo};
  endfunction

  function automatic void push8(input logic [7:0] v);
    store8(STACK_PAGE | {8'h00, cpu_sp}, v);
    cpu_sp = cpu_sp - 8'd1;
  endfunction

  function automatic logic [7:0] pull8();
    cpu_sp = cpu_sp + 8'd1;
    return mem_img[STACK_PAGE | {8'h00, cpu_sp}];
  endfunction

  function automatic logic [7:0] nz(input logic [7:0] v);
    cpu_fl[FL_Z] = (v == 8'h00);
    cpu_fl[FL_N] = v[7];
    return v;
  endfunction

  function automatic void add_carry(input logic [7:0] m);
    logic [8:0] sum;
    sum          = {1'b0, cpu_a} + {1'b0, m} + {8'h00, cpu_fl[FL_C]};
    cpu_fl[FL_C] = sum[8];
    cpu_fl[FL_V] = ((~(cpu_a ^ m)) & (cpu_a ^ sum[7:0]) & SIGN_BIT) != 8'h00;
    cpu_a        = nz(sum[7:0]);
  endfunction

  function automatic void sub_borrow(input logic [7:0] m);
    logic [8:0] need;
    logic [7:0] r;
    need         = {1'b0, m} + {8'h00, ~cpu_fl[FL_C]};
    r            = cpu_a - need[7:0];
    cpu_fl[FL_C] = {1'b0, cpu_a} >= need;
    cpu_fl[FL_V] = ((cpu_a ^ r) & (cpu_a ^ m) & SIGN_BIT) != 8'h00;
    cpu_a        = nz(r);
  endfunction

  function automatic void compare_reg(input logic [7:0] r, input logic [7:0] m);
    logic [7:0] d;
    cpu_fl[FL_C] = r >= m;
    d = nz(r - m);
  endfunction

  function automatic void branch_if(input bit take);
    logic [7:0] off;
    off = fetch8();
    if (take) cpu_pc = cpu_pc + {{8{off[7]}}, off};
  endfunction

  // Runs one instruction on the shadow registers and returns the stop code.
  function automatic stop_t run_instr();
    logic [7:0]  op;
    logic [15:0] a;
    logic [7:0]  lo;
    logic [7:0]  hi;
    op = fetch8();
    case (op)
      OP_ADC_I:  add_carry(fetch8());
      OP_ADC_A:  add_carry(mem_img[fetch16()]);
      OP_AND_I:  cpu_a = nz(cpu_a & fetch8());
      OP_AND_A:  cpu_a = nz(cpu_a & mem_img[fetch16()]);
      OP_EOR_I:  cpu_a = nz(cpu_a ^ fetch8());
      OP_EOR_A:  cpu_a = nz(cpu_a ^ mem_img[fetch16()]);
      OP_EOR_Z:  cpu_a = nz(cpu_a ^ mem_img[{8'h00, fetch8()}]);
      OP_ASL: begin
        cpu_fl[FL_C] = cpu_a[7];
        cpu_a = nz({cpu_a[6:0], 1'b0});
      end
      OP_LSR: begin
        cpu_fl[FL_C] = cpu_a[0];
        cpu_a = nz({1'b0, cpu_a[7:1]});
      end
      OP_BEQ:    branch_if(cpu_fl[FL_Z]);
      OP_BNE:    branch_if(!cpu_fl[FL_Z]);
      OP_BMI:    branch_if(cpu_fl[FL_N]);
      OP_BPL:    branch_if(!cpu_fl[FL_N]);
      OP_BCC:    branch_if(!cpu_fl[FL_C]);
      OP_BVS:    branch_if(cpu_fl[FL_V]);
      OP_CMP_I:  compare_reg(cpu_a, fetch8());
      OP_CMP_A:  compare_reg(cpu_a, mem_img[fetch16()]);
      OP_CPX_I:  compare_reg(cpu_x, fetch8());
      OP_CPY_I:  compare_reg(cpu_y, fetch8());
      OP_CPY_A:  compare_reg(cpu_y, mem_img[fetch16()]);
      OP_CPY_Z:  compare_reg(cpu_y, mem_img[{8'h00, fetch8()}]);
      OP_INX:    cpu_x = nz(cpu_x + 8'd1);
      OP_INY:    cpu_y = nz(cpu_y + 8'd1);
      OP_DEY:    cpu_y = nz(cpu_y - 8'd1);
      OP_DEA:    cpu_a = nz(cpu_a - 8'd1);
      OP_JMP:    cpu_pc = fetch16();
      OP_JSR: begin
        // The return address pushed is that of the next instruction itself.
        a = fetch16();
        push8(cpu_pc[15:8]);
        push8(cpu_pc[7:0]);
        cpu_pc = a;
      end
      OP_RTS: begin
        lo = pull8();
        hi = pull8();
        cpu_pc = {hi, lo};
      end
      OP_LDA_I:  cpu_a = nz(fetch8());
      OP_LDA_Z:  cpu_a = nz(mem_img[{8'h00, fetch8()}]);
      OP_LDA_A:  cpu_a = nz(mem_img[fetch16()]);
      OP_LDA_AY: cpu_a = nz(mem_img[fetch16() + {8'h00, cpu_y}]);
      OP_LDX_I:  cpu_x = nz(fetch8());
      OP_LDX_Z:  cpu_x = nz(mem_img[{8'h00, fetch8()}]);
      OP_LDY_I:  cpu_y = nz(fetch8());
      OP_LDY_A:  cpu_y = nz(mem_img[fetch16()]);
      OP_NOP: ;
      OP_PHA:    push8(cpu_a);
      OP_PLA:    cpu_a = nz(pull8());
      OP_SBC_I:  sub_borrow(fetch8());
      OP_SBC_A:  sub_borrow(mem_img[fetch16()]);
      OP_STA_A:  store8(fetch16(), cpu_a);
      OP_STA_AX: store8(fetch16() + {8'h00, cpu_x}, cpu_a);
      OP_STA_AY: store8(fetch16() + {8'h00, cpu_y}, cpu_a);
      OP_STA_Z:  store8({8'h00, fetch8()}, cpu_a);
      OP_STX_Z:  store8({8'h00, fetch8()}, cpu_x);
      OP_STY_Z:  store8({8'h00, fetch8()}, cpu_y);
      OP_TAX:    cpu_x = nz(cpu_a);
      OP_TXA:    cpu_a = nz(cpu_x);
      OP_BRK:    return STOP_BRK;
      default:   return STOP_UNKNOWN;
    endcase
    return STOP_NONE;
  endfunction

  function automatic out_item_t predict_beat(input in_item_t it);
    out_item_t r;
    stop_t     st;
    st          = STOP_NONE;
    r.read_data = 8'h00;
    case (mode_t'(it.mode))
      MODE_WRITE: store8(it.address, it.data);
      MODE_READ:  r.read_data = mem_img[it.address];
      MODE_RESET: begin
        cpu_a  = 8'h00;
        cpu_x  = 8'h00;
        cpu_y  = 8'h00;
        cpu_fl = 4'h0;
        cpu_sp = SP_INIT;
        cpu_pc = {mem_img[VEC_HI], mem_img[VEC_LO]};
      end
      default:    st = run_instr();
    endcase
    r.program_counter = cpu_pc;
    r.accumulator     = cpu_a;
    r.index_x         = cpu_x;
    r.index_y         = cpu_y;
    r.stack_pointer   = cpu_sp;
    r.flags           = cpu_fl;
    r.stopped         = st;
    return r;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      cpu_pc = 16'h0000;
      cpu_a  = 8'h00;
      cpu_x  = 8'h00;
      cpu_y  = 8'h00;
      cpu_sp = SP_INIT;
      cpu_fl = 4'h0;
      expected_beats.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_beats.size() == 0) begin
          report("result beat with nothing expected");
        end else begin
          want = expected_beats.pop_front();
          if (out_item.read_data !== want.read_data)
            report($sformatf("read_data %h, want %h", out_item.read_data, want.read_data));
          if (out_item.program_counter !== want.program_counter)
            report($sformatf("program_counter %h, want %h",
                             out_item.program_counter, want.program_counter));
          if (out_item.accumulator !== want.accumulator)
            report($sformatf("accumulator %h, want %h", out_item.accumulator, want.accumulator));
          if (out_item.index_x !== want.index_x)
            report($sformatf("index_x %h, want %h", out_item.index_x, want.index_x));
          if (out_item.index_y !== want.index_y)
            report($sformatf("index_y %h, want %h", out_item.index_y, want.index_y));
          if (out_item.stack_pointer !== want.stack_pointer)
            report($sformatf("stack_pointer %h, want %h",
                             out_item.stack_pointer, want.stack_pointer));
          if (out_item.flags !== want.flags)
            report($sformatf("flags %h, want %h", out_item.flags, want.flags));
          if (out_item.stopped !== want.stopped)
            report($sformatf("stopped %h, want %h", out_item.stopped, want.stopped));
        end
      end
      if (in_valid && in_ready) expected_beats.push_back(predict_beat(in_item));
    end
    pending = expected_beats.size();
  end

endmodule

### verif/eight_bit_accumulator_cpu_subset_top_tb.sv
`timescale 1ns / 1ps
// Testbench top: drives random and directed CPU items and gives the verdict.
module eight_bit_accumulator_cpu_subset_top_tb;
  import eba_pkg::*;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   beats_sent;
  int   burst_left;

  // Every covered opcode apart from BRK, which is handled on its own.
  localparam logic [7:0] COVERED_OPS [0:48] = '{
    OP_ADC_I, OP_ADC_A, OP_AND_I, OP_AND_A, OP_ASL, OP_LSR, OP_BEQ, OP_BNE,
    OP_BMI, OP_BPL, OP_BCC, OP_BVS, OP_CMP_I, OP_CMP_A, OP_CPX_I, OP_CPY_I,
    OP_CPY_A, OP_CPY_Z, OP_INX, OP_INY, OP_DEY, OP_DEA, OP_JMP, OP_JSR,
    OP_RTS, OP_LDA_I, OP_LDA_Z, OP_LDA_A, OP_LDA_AY, OP_LDX_I, OP_LDX_Z,
    OP_LDY_I, OP_LDY_A, OP_NOP, OP_PHA, OP_PLA, OP_SBC_I, OP_SBC_A,
    OP_STA_A, OP_STA_AX, OP_STA_AY, OP_STA_Z, OP_STX_Z, OP_STY_Z,
    OP_EOR_I, OP_EOR_A, OP_EOR_Z, OP_TAX, OP_TXA
  };

  eba_if #(.T(in_item_t))  in_ch  (clk);
  eba_if #(.T(out_item_t)) out_ch (clk);

  eight_bit_accumulator_cpu_subset_top u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // The checker sees both channels exactly as the block does.
  eba_cpu_checker u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_item    (in_ch.payload),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_item   (out_ch.payload),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Operand and data bytes lean towards the values at the edges of the range.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 5))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h80;
      3:       return 8'h7F;
      default: return 8'($urandom);
    endcase
  endfunction

  // Mostly covered opcodes, with some BRK and some arbitrary bytes that are
  // usually unknown to the core.
  function automatic logic [7:0] pick_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return OP_BRK;
    if (r < 10) return 8'($urandom);
    return COVERED_OPS[$urandom_range(0, 48)];
  endfunction

  // Sends one beat. The sender works in bursts; valid is dropped after each
  // accepted beat, so the next item is always built from settled predictor
  // state. The block takes only one item at a time anyway.
  task automatic send(input mode_t m, input logic [15:0] a, input logic [7:0] d);
    if (burst_left == 0) begin
      if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 16);
    end
    in_ch.valid   <= 1'b1;
    in_ch.payload <= '{mode: m, address: a, data: d};
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    in_ch.valid <= 1'b0;
    burst_left--;
    beats_sent++;
    @(posedge clk);
  endtask

  task automatic put(input logic [15:0] a, input logic [7:0] d);
    send(MODE_WRITE, a, d);
  endtask

  // Finds the first byte that the next instruction would read but that has
  // never been written: opcode, operands, data byte and stack bytes.
  function automatic bit exec_gap(output logic [15:0] g);
    logic [15:0] pc;
    logic [15:0] ea;
    logic [7:0]  op;
    logic [7:0]  sp;
    int          nb;
    pc = u_chk.cpu_pc;
    sp = u_chk.cpu_sp;
    g  = pc;
    if (!u_chk.mem_known[pc]) return 1'b1;
    op = u_chk.mem_img[pc];
    nb = opr_bytes(op);
    for (int i = 1; i <= nb; i++) begin
      g = pc + 16'(i);
      if (!u_chk.mem_known[g]) return 1'b1;
    end
    if (needs_data(op)) begin
      if (nb == 1) ea = {8'h00, u_chk.mem_img[pc + 16'd1]};
      else ea = {u_chk.mem_img[pc + 16'd2], u_chk.mem_img[pc + 16'd1]};
      if (op == OP_LDA_AY) ea = ea + {8'h00, u_chk.cpu_y};
      g = ea;
      if (!u_chk.mem_known[g]) return 1'b1;
    end
    if (op == OP_RTS || op == OP_PLA) begin
      g = STACK_PAGE | {8'h00, sp + 8'd1};
      if (!u_chk.mem_known[g]) return 1'b1;
    end
    if (op == OP_RTS) begin
      g = STACK_PAGE | {8'h00, sp + 8'd2};
      if (!u_chk.mem_known[g]) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Lays down an instruction at the current PC (or reuses what is there),
  // fills every byte it would read that is still unwritten, then runs it.
  task automatic run_exec(input bit forced, input logic [7:0] fop);
    logic [15:0] pc;
    logic [15:0] g;
    logic [7:0]  op;
    pc = u_chk.cpu_pc;
    if (forced) put(pc, fop);
    else if (!u_chk.mem_known[pc] || $urandom_range(0, 4) != 0) put(pc, pick_op());
    op = u_chk.mem_img[pc];
    for (int i = 1; i <= opr_bytes(op); i++)
      if ($urandom_range(0, 2) != 0) put(pc + 16'(i), pick_byte());
    while (exec_gap(g)) put(g, pick_byte());
    send(MODE_EXEC, 16'($urandom), 8'($urandom));
  endtask

  task automatic core_reset(input logic [15:0] vec);
    put(VEC_LO, vec[7:0]);
    put(VEC_HI, vec[15:8]);
    send(MODE_RESET, 16'($urandom), 8'($urandom));
  endtask

  // Result side: the receiver changes its stall pattern every so often and,
  // once, holds off for a long stretch so that the block backs up onto the
  // sender while it keeps offering.
  initial begin
    int rx_cycle;
    int style;
    rx_cycle = 0;
    style    = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      rx_cycle++;
      if (rx_cycle == 2000) begin
        out_ch.ready <= 1'b0;
        repeat (400) @(posedge clk);
      end
      if (rx_cycle % 64 == 0) style = $urandom_range(0, 3);
      case (style)
        0:       out_ch.ready <= 1'b1;
        1:       out_ch.ready <= 1'($urandom);
        2:       out_ch.ready <= (rx_cycle % 4 == 0);
        default: out_ch.ready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  initial begin
    int r;
    logic [15:0] a;
    beats_sent = 0;
    burst_left = 0;
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.payload <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: boot from a vector, read it back, then run every
    // covered opcode once, BRK and an unknown opcode.
    core_reset(16'h0200);
    send(MODE_READ, VEC_LO, 8'hFF);
    foreach (COVERED_OPS[i]) run_exec(1'b1, COVERED_OPS[i]);
    run_exec(1'b1, OP_BRK);
    run_exec(1'b1, 8'hFF);
    // After a stop the next instruction runs normally.
    run_exec(1'b1, OP_INX);
    // Pulling with the stack pointer back at FF wraps it round to 00.
    run_exec(1'b1, OP_PLA);
    // PC at the top of memory: the operand fetch wraps round to address zero.
    core_reset(16'hFFFF);
    run_exec(1'b1, OP_LDA_AY);

    // Random part: mostly instruction runs, with stray writes, reads of
    // written bytes and core resets to random vectors mixed in.
    while (beats_sent < 1150) begin
      r = $urandom_range(0, 99);
      a = 16'($urandom);
      if (r < 6) begin
        put(a, 8'($urandom));
      end else if (r < 12) begin
        if (!u_chk.mem_known[a]) put(a, pick_byte());
        send(MODE_READ, a, 8'($urandom));
      end else if (r < 15) begin
        core_reset(a);
      end else begin
        run_exec(1'b0, 8'h00);
      end
    end

    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS eight_bit_accumulator_cpu_subset_top");
    end else begin
      $display("FAIL eight_bit_accumulator_cpu_subset_top");
    end
    $finish;
  end

  // Guard against a hang: far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("FAIL eight_bit_accumulator_cpu_subset_top");
    $finish;
  end

endmodule
